FILE: hdl/mlpt_pkg.sv
// Shared constants and types for the multilevel page table walker.
package mlpt_pkg;
  localparam int MaxLevels    = 4;
  localparam int MaxLevelBits = 8;
  localparam int NodePool     = 64;
  localparam int AddrBits     = 32;
  localparam int NodeW        = $clog2(NodePool);
  localparam int SlotW        = NodeW + MaxLevelBits;
  localparam int Depth        = NodePool * (1 << MaxLevelBits);
  localparam int EntryW       = 15;
  localparam int FrameW       = 14;
  localparam int FrameLimit   = 16384;
  localparam int LvlW         = $clog2(MaxLevels);
  localparam int RemW         = $clog2(AddrBits + 1);

  localparam logic [2:0] CFG_LEVEL_COUNT = 3'd0;
  localparam logic [2:0] CFG_LEVEL0      = 3'd1;
  localparam logic [2:0] CFG_LEVEL3      = 3'd4;

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_SPLIT = 7'b0000010,
    ST_READ  = 7'b0000100,
    ST_CHECK = 7'b0001000,
    ST_ALLOC = 7'b0010000,
    ST_LEAF  = 7'b0100000,
    ST_DONE  = 7'b1000000
  } state_t;
endpackage

FILE: hdl/multilevel_page_table_walker.sv
// Top level of the multilevel radix page table walker.
// Usage: pulse start with in_logical_address while busy is low. The block
// splits the address into configured level fields, walks the radix tree
// held in a 16384-entry node memory (one registered read per level until an
// entry is missing), allocates missing nodes and the leaf entry, then
// presents one result word for a single cycle marked by out_valid. busy
// drops in the out_valid cycle, so the next word can be taken at the edge
// that ends it.
// Configuration is to be written through cfg_we/cfg_index/cfg_wdata while
// idle, by the user; the block itself does not enforce this.
// After reset the valid bits are swept with busy high; the counters clear
// and the root node is the only node in use.
// Results cannot be stalled: the receiver must take out_valid words.
module multilevel_page_table_walker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] in_logical_address,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [3:0]  cfg_wdata,
  output logic        out_valid,
  output logic        out_hit,
  output logic [13:0] out_frame_number,
  output logic [31:0] out_physical_address,
  output logic [30:0] out_page_offset,
  output logic        out_table_full,
  output logic [31:0] out_hits_so_far,
  output logic [14:0] out_frames_used
);
  import mlpt_pkg::*;

  state_t state_r, state_nxt;
  logic [2:0] lvl_count_r;
  logic [3:0] lvl_bits_r [MaxLevels];
  logic [31:0] addr_r;
  logic [LvlW-1:0] d_r, levels_r;
  logic [RemW-1:0] rem_r;
  logic [MaxLevelBits-1:0] idx_r [MaxLevels];
  logic [NodeW-1:0] node_r;
  logic [6:0] nodes_used_r;
  logic [14:0] next_frame_r;
  logic [31:0] hit_total_r;
  logic [EntryW-1:0] rd_data;
  logic rd_valid, clearing, wr_en;
  logic [SlotW-1:0] rd_addr, wr_addr;
  logic [EntryW-1:0] wr_data;
  logic [30:0] offset_r;

  // walk bookkeeping
  logic [2:0] lc;
  logic [3:0] b_cur;
  logic [RemW-1:0] b_use;
  logic last_lvl;
  logic next_last;

  mlpt_store u_store (
    .clk, .rst_n, .rd_addr, .rd_data, .rd_valid,
    .wr_en, .wr_addr, .wr_data, .clearing
  );

  // config writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lvl_count_r <= 3'd1;
      for (int i = 0; i < MaxLevels; i++) lvl_bits_r[i] <= 4'd8;
    end else if (cfg_we) begin
      if (cfg_index == CFG_LEVEL_COUNT) lvl_count_r <= cfg_wdata[2:0];
      else if (cfg_index >= CFG_LEVEL0 && cfg_index <= CFG_LEVEL3)
        lvl_bits_r[2'(cfg_index - CFG_LEVEL0)] <= cfg_wdata;
    end
  end

  always_comb begin
    lc = lvl_count_r;
    if (lc == 3'd0) lc = 3'd1;
    if (lc > 3'(MaxLevels)) lc = 3'(MaxLevels);
    b_cur = lvl_bits_r[d_r];
    if (b_cur == 4'd0) b_cur = 4'd1;
    if (b_cur > 4'(MaxLevelBits)) b_cur = 4'(MaxLevelBits);
    b_use = (RemW'(b_cur) > rem_r) ? rem_r : RemW'(b_cur);
  end

  assign last_lvl  = (d_r == levels_r);
  assign next_last = ((d_r + 1'b1) == levels_r);
  assign rd_addr   = {node_r, idx_r[d_r]};
  assign busy      = (state_r != ST_IDLE) || clearing;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (start && !clearing) state_nxt = ST_SPLIT;
      ST_SPLIT: if (d_r == levels_r) state_nxt = ST_READ;
      ST_READ:  state_nxt = ST_CHECK;
      ST_CHECK: state_nxt = ST_DONE;
      ST_ALLOC: state_nxt = next_last ? ST_LEAF : ST_ALLOC;
      ST_LEAF:  state_nxt = ST_DONE;
      ST_DONE:  state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
    if (state_r == ST_CHECK) begin
      if (!last_lvl && rd_valid && rd_data < EntryW'(NodePool)) state_nxt = ST_READ;
      else if (last_lvl && rd_valid) state_nxt = ST_DONE;
      else if (32'(nodes_used_r) + 32'(levels_r - d_r) > 32'(NodePool)
               || next_frame_r >= 15'(FrameLimit)) state_nxt = ST_DONE;
      else state_nxt = last_lvl ? ST_LEAF : ST_ALLOC;
    end
  end

  // memory writes during allocation
  always_comb begin
    wr_en   = (state_r == ST_ALLOC) || (state_r == ST_LEAF);
    wr_addr = {node_r, idx_r[d_r]};
    wr_data = (state_r == ST_LEAF) ? next_frame_r : EntryW'(nodes_used_r);
  end

  logic [31:0] mask;
  assign mask = (rem_r >= RemW'(32)) ? '1 : ((32'd1 << rem_r) - 32'd1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      out_valid <= 1'b0;
      nodes_used_r <= 7'd1;
      next_frame_r <= '0;
      hit_total_r <= '0;
    end else begin
      state_r <= state_nxt;
      out_valid <= 1'b0;
      unique case (state_r)
        ST_IDLE: begin
          addr_r <= in_logical_address;
          d_r <= '0;
          rem_r <= RemW'(AddrBits);
          levels_r <= LvlW'(lc - 3'd1);
          node_r <= '0;
          out_hit <= 1'b0;
          out_table_full <= 1'b0;
        end
        ST_SPLIT: begin
          // peel one level field off the top
          idx_r[d_r] <= MaxLevelBits'((addr_r >> (rem_r - b_use))
                         & ((32'd1 << b_use) - 32'd1));
          rem_r <= rem_r - b_use;
          if (d_r == levels_r) d_r <= '0;
          else d_r <= d_r + 1'b1;
        end
        ST_READ: offset_r <= 31'(addr_r & mask);
        ST_CHECK: begin
          if (!last_lvl && rd_valid && rd_data < EntryW'(NodePool)) begin
            node_r <= NodeW'(rd_data);
            d_r <= d_r + 1'b1;
          end else if (last_lvl && rd_valid) begin
            out_hit <= 1'b1;
            out_frame_number <= rd_data[FrameW-1:0];
            if (hit_total_r != '1) hit_total_r <= hit_total_r + 1'b1;
          end else if (32'(nodes_used_r) + 32'(levels_r - d_r) > 32'(NodePool)
                       || next_frame_r >= 15'(FrameLimit)) begin
            out_table_full <= 1'b1;
            out_frame_number <= '0;
          end
        end
        ST_ALLOC: begin
          node_r <= NodeW'(nodes_used_r);
          nodes_used_r <= nodes_used_r + 1'b1;
          if (!last_lvl) d_r <= d_r + 1'b1;
        end
        ST_LEAF: begin
          out_frame_number <= next_frame_r[FrameW-1:0];
          next_frame_r <= next_frame_r + 1'b1;
        end
        ST_DONE: begin
          out_valid <= 1'b1;
          out_page_offset <= offset_r;
          out_physical_address <= out_table_full ? '0 :
            ((32'(out_frame_number) << rem_r) | 32'(offset_r));
          out_hits_so_far <= hit_total_r;
          out_frames_used <= next_frame_r;
        end
        default: ;
      endcase
    end
  end
endmodule

FILE: hdl/mlpt_store.sv
// Node entry memory with per-entry valid bits cleared by a sweep after reset.
module mlpt_store (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [mlpt_pkg::SlotW-1:0]  rd_addr,
  output logic [mlpt_pkg::EntryW-1:0] rd_data,
  output logic                        rd_valid,
  input  logic                        wr_en,
  input  logic [mlpt_pkg::SlotW-1:0]  wr_addr,
  input  logic [mlpt_pkg::EntryW-1:0] wr_data,
  output logic                        clearing
);
  import mlpt_pkg::*;

  logic [EntryW-1:0] mem [Depth];
  logic              vmem [Depth];
  logic [SlotW:0]    clr_r;

  // sweep valid memory after reset
  always_ff @(posedge clk) begin
    if (!rst_n) clr_r <= '0;
    else if (!clr_r[SlotW]) clr_r <= clr_r + 1'b1;
  end
  assign clearing = !clr_r[SlotW];

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (clearing) vmem[clr_r[SlotW-1:0]] <= 1'b0;
    else if (wr_en) vmem[wr_addr] <= 1'b1;
    rd_valid <= vmem[rd_addr];
  end
endmodule
